// ----- src/bmm_pkg.sv -----
// package: shared types and codes for the bipartite matching block
package bmm_pkg;

  localparam int unsigned VtxW   = 5;
  localparam int unsigned CountW = 6;
  localparam int unsigned FuncW  = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_COMPUTE = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  localparam logic CFG_LEFT  = 1'b0;
  localparam logic CFG_RIGHT = 1'b1;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [VtxW-1:0]  left_vertex;
    logic [VtxW-1:0]  right_vertex;
  } in_word_t;

  typedef struct packed {
    logic              pair_valid;
    logic [VtxW-1:0]   pair_left;
    logic [VtxW-1:0]   pair_right;
    logic [CountW-1:0] match_total;
    logic              last;
  } out_word_t;

endpackage

// ----- src/bmm_seq.sv -----
// module: matching sequencer with greedy pass, dfs stack and emit sweep
module bmm_seq #(
  parameter int unsigned MAX_LEFT  = 32,
  parameter int unsigned MAX_RIGHT = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  bmm_pkg::in_word_t        cmd_i,
  input  logic [bmm_pkg::CountW-1:0] n_i,
  input  logic [bmm_pkg::CountW-1:0] m_i,
  output logic                     busy_o,
  output logic                     valid_o,
  output bmm_pkg::out_word_t       word_o
);
  localparam int unsigned LW = $clog2(MAX_LEFT);
  localparam int unsigned RW = $clog2(MAX_RIGHT);
  localparam int unsigned LC = $clog2(MAX_LEFT + 1);
  localparam int unsigned RC = $clog2(MAX_RIGHT + 1);
  localparam int unsigned CW = bmm_pkg::CountW;
  localparam int unsigned VW = bmm_pkg::VtxW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_GRD   = 8'b00000010,
    S_AUGST = 8'b00000100,
    S_DFS   = 8'b00001000,
    S_APPLY = 8'b00010000,
    S_EMIT  = 8'b00100000,
    S_CLR   = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic [MAX_RIGHT-1:0] adj_q [MAX_LEFT];
  logic [LW-1:0]        part_q [MAX_RIGHT];
  logic [MAX_RIGHT-1:0] pvalid_q;
  logic [MAX_LEFT-1:0]  visited_q;
  logic [MAX_LEFT-1:0]  gdone_q;
  logic [LW-1:0]        stk_l_q [MAX_LEFT];
  logic [RC-1:0]        stk_r_q [MAX_LEFT];
  logic [LC-1:0]        depth_q;
  logic [LC-1:0]        lv_q;
  logic [RC-1:0]        ri_q;
  logic [CW-1:0]        cnt_q;
  logic                 emitted_q;
  logic [LC-1:0]        n_q;
  logic [RC-1:0]        m_q;
  logic [MAX_RIGHT-1:0] inrange;

  // effective counts, saturated
  logic [LC-1:0] n_eff;
  logic [RC-1:0] m_eff;
  assign n_eff = (32'(n_i) > MAX_LEFT)  ? LC'(MAX_LEFT)  : LC'(n_i);
  assign m_eff = (32'(m_i) > MAX_RIGHT) ? RC'(MAX_RIGHT) : RC'(m_i);

  always_comb begin
    for (int r = 0; r < MAX_RIGHT; r++) begin
      inrange[r] = (RC'(r) < m_q);
    end
  end

  // priority search unit, shared by greedy and dfs
  logic [LW-1:0]        row_sel;
  logic [RC-1:0]        from_sel;
  logic [MAX_RIGHT-1:0] cand;
  logic                 hit;
  logic [RW-1:0]        hit_r;
  logic [LW-1:0]        top;
  assign top = depth_q[LW-1:0] - LW'(1);
  always_comb begin
    row_sel  = (state_q == S_GRD) ? lv_q[LW-1:0] : stk_l_q[top];
    from_sel = (state_q == S_GRD) ? '0 : stk_r_q[top];
    for (int r = 0; r < MAX_RIGHT; r++) begin
      cand[r] = adj_q[row_sel][r] && inrange[r] && (RC'(r) >= from_sel) &&
                ((state_q != S_GRD) || !pvalid_q[r]);
    end
    hit   = 1'b0;
    hit_r = '0;
    for (int r = MAX_RIGHT - 1; r >= 0; r--) begin
      if (cand[r]) begin
        hit   = 1'b1;
        hit_r = RW'(r);
      end
    end
  end

  logic [LW-1:0] child;
  assign child = part_q[hit_r];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          case (bmm_pkg::func_e'(cmd_i.func))
            bmm_pkg::FUNC_COMPUTE: state_d = (n_eff == '0) ? S_EMIT : S_GRD;
            bmm_pkg::FUNC_CLEAR:   state_d = S_CLR;
            default:               state_d = S_IDLE;
          endcase
        end
      end
      S_GRD:   if (lv_q == n_q - LC'(1)) state_d = S_AUGST;
      S_AUGST: begin
        if (lv_q == n_q) state_d = S_EMIT;
        else if (!gdone_q[lv_q[LW-1:0]]) state_d = S_DFS;
      end
      S_DFS: begin
        if (!hit) begin
          if (depth_q == LC'(1)) state_d = S_AUGST;
        end else if (!pvalid_q[hit_r]) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: if (depth_q == LC'(1)) state_d = S_AUGST;
      S_EMIT:  if (ri_q == m_q - RC'(1) || m_q == '0) state_d = S_FIN;
      S_CLR:   state_d = S_IDLE;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pvalid_q  <= '0;
      depth_q   <= '0;
      cnt_q     <= '0;
      lv_q      <= '0;
      ri_q      <= '0;
      emitted_q <= 1'b0;
      visited_q <= '0;
      gdone_q   <= '0;
      n_q       <= '0;
      m_q       <= '0;
      for (int i = 0; i < MAX_LEFT; i++) adj_q[i] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (go_i) begin
            if (cmd_i.func == bmm_pkg::FUNC_ADD) begin
              if (32'(cmd_i.left_vertex) < MAX_LEFT && 32'(cmd_i.right_vertex) < MAX_RIGHT)
                adj_q[LW'(cmd_i.left_vertex)][RW'(cmd_i.right_vertex)] <= 1'b1;
            end
            n_q       <= n_eff;
            m_q       <= m_eff;
            lv_q      <= '0;
            ri_q      <= '0;
            emitted_q <= 1'b0;
            if (cmd_i.func == bmm_pkg::FUNC_COMPUTE) begin
              pvalid_q <= '0;
              gdone_q  <= '0;
              cnt_q    <= '0;
            end
          end
        end
        S_GRD: begin
          if (hit) begin
            part_q[hit_r]             <= lv_q[LW-1:0];
            pvalid_q[hit_r]           <= 1'b1;
            gdone_q[lv_q[LW-1:0]]     <= 1'b1;
            cnt_q                     <= cnt_q + CW'(1);
          end
          lv_q <= (state_d == S_AUGST) ? '0 : lv_q + LC'(1);
        end
        S_AUGST: begin
          if (lv_q != n_q) begin
            if (!gdone_q[lv_q[LW-1:0]]) begin
              visited_q  <= MAX_LEFT'(1) << lv_q[LW-1:0];
              stk_l_q[0] <= lv_q[LW-1:0];
              stk_r_q[0] <= '0;
              depth_q    <= LC'(1);
            end
            lv_q <= lv_q + LC'(1);
          end
        end
        S_DFS: begin
          if (!hit) begin
            depth_q <= depth_q - LC'(1);
            if (depth_q > LC'(1)) stk_r_q[top - LW'(1)] <= stk_r_q[top - LW'(1)] + RC'(1);
          end else if (!pvalid_q[hit_r]) begin
            stk_r_q[top] <= RC'(hit_r);
            cnt_q        <= cnt_q + CW'(1);
          end else if (visited_q[child] || depth_q >= LC'(MAX_LEFT)) begin
            stk_r_q[top] <= RC'(hit_r) + RC'(1);
          end else begin
            stk_r_q[top]               <= RC'(hit_r);
            visited_q[child]           <= 1'b1;
            stk_l_q[depth_q[LW-1:0]]   <= child;
            stk_r_q[depth_q[LW-1:0]]   <= '0;
            depth_q                    <= depth_q + LC'(1);
          end
        end
        S_APPLY: begin
          // flip one frame per cycle, top down
          part_q[stk_r_q[top][RW-1:0]]   <= stk_l_q[top];
          pvalid_q[stk_r_q[top][RW-1:0]] <= 1'b1;
          depth_q <= depth_q - LC'(1);
        end
        S_EMIT: begin
          if (m_q != '0 && pvalid_q[ri_q[RW-1:0]]) emitted_q <= 1'b1;
          ri_q <= ri_q + RC'(1);
        end
        S_CLR: begin
          pvalid_q <= '0;
          cnt_q    <= '0;
          for (int i = 0; i < MAX_LEFT; i++) adj_q[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  // hold each pair until the next one is found or the sweep ends, so last can be set on the final one
  logic              hold_q;
  logic [VW-1:0]     hl_q, hr_q;
  logic              cur;
  assign cur = (state_q == S_EMIT) && (m_q != '0) && pvalid_q[ri_q[RW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      hl_q    <= '0;
      hr_q    <= '0;
      valid_o <= 1'b0;
      word_o  <= '0;
    end else begin
      valid_o <= (cur && hold_q) || (state_q == S_FIN);
      if (state_q == S_IDLE) begin
        hold_q <= 1'b0;
      end else if (cur) begin
        hold_q <= 1'b1;
        hl_q   <= VW'(part_q[ri_q[RW-1:0]]);
        hr_q   <= VW'(ri_q);
      end
      if (cur) begin
        if (hold_q) word_o <= {1'b1, hl_q, hr_q, cnt_q, 1'b0};
      end else if (state_q == S_FIN) begin
        if (emitted_q) word_o <= {1'b1, hl_q, hr_q, cnt_q, 1'b1};
        else word_o <= {1'b0, VW'(0), VW'(0), CW'(0), 1'b1};
      end
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- src/bipartite_max_matching.sv -----
// top level: bipartite maximum matching engine with configuration registers
// add edge: taken at its accepting edge, never raises busy; clear: busy only for its clear state
// compute: greedy pass over the left vertices (none when n is zero), then a scan that runs a dfs
// and flip per unmatched left vertex, a right sweep and a closing state; words trail the sweep
// throughput: one item at a time; busy drops in the cycle the last word appears
// reset: empty graph, no matching, counts 32; the receiver cannot stall
module bipartite_max_matching #(
  parameter int unsigned MAX_LEFT  = 32,
  parameter int unsigned MAX_RIGHT = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bmm_pkg::in_word_t    in_word_i,
  output logic                 done_o,
  output bmm_pkg::out_word_t   out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [bmm_pkg::CountW-1:0] cfg_data_i
);
  logic [bmm_pkg::CountW-1:0] left_count_q, right_count_q;

  // count registers, latched by the sequencer when a command is taken
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_count_q  <= bmm_pkg::CountW'(32);
      right_count_q <= bmm_pkg::CountW'(32);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bmm_pkg::CFG_LEFT:  left_count_q  <= cfg_data_i;
        bmm_pkg::CFG_RIGHT: right_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bmm_seq #(.MAX_LEFT(MAX_LEFT), .MAX_RIGHT(MAX_RIGHT)) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (start && !busy),
    .cmd_i   (in_word_i),
    .n_i     (left_count_q),
    .m_i     (right_count_q),
    .busy_o  (busy),
    .valid_o (done_o),
    .word_o  (out_word_o)
  );

  // a result word only appears while a command is in flight or right after
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result word without a command");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_word_o.last) |=> !done_o) else $error("word after last");

endmodule

// ----- tb/sv/bipartite_max_matching_tb.sv -----
// testbench: bipartite maximum matching engine against an in-bench matching predictor
module bipartite_max_matching_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  bmm_pkg::in_word_t          in_word_i = '0;
  logic                       done_o;
  bmm_pkg::out_word_t         out_word_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic                       cfg_index_i = bmm_pkg::CFG_LEFT;
  logic [bmm_pkg::CountW-1:0] cfg_data_i = '0;

  bipartite_max_matching DUT (
    .clk_i, .rst_ni, .start, .busy, .in_word_i, .done_o, .out_word_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // predictor state: graph rows, partner table and the two counts
  logic [31:0]       adj_rows [32];
  logic [4:0]        partner_of [32];
  logic [31:0]       partner_set;
  int unsigned       n_left = 32;
  int unsigned       n_right = 32;

  bmm_pkg::out_word_t pending_words [$];
  int unsigned       error_count = 0;
  int unsigned       sender_gap_pct = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // neighbour search from one left vertex, ascending, visiting each left vertex once
  function automatic bit try_augment(input int unsigned root);
    logic [31:0] seen;
    int unsigned st_l [32];
    int unsigned st_r [32];
    int unsigned depth;
    int unsigned top;
    int unsigned r;
    int unsigned kid;
    seen = 32'b1 << root;
    depth = 1;
    st_l[0] = root;
    st_r[0] = 0;
    while (depth > 0) begin
      top = depth - 1;
      r = st_r[top];
      while (r < n_right && !adj_rows[st_l[top]][r]) r++;
      if (r >= n_right) begin
        depth--;
        if (depth > 0) st_r[depth-1]++;
        continue;
      end
      st_r[top] = r;
      if (!partner_set[r]) begin
        for (int i = 0; i < depth; i++) begin
          partner_of[st_r[i]] = st_l[i][4:0];
          partner_set[st_r[i]] = 1'b1;
        end
        return 1'b1;
      end
      kid = partner_of[r];
      if (seen[kid] || depth >= 32) begin
        st_r[top] = r + 1;
        continue;
      end
      seen[kid] = 1'b1;
      st_l[depth] = kid;
      st_r[depth] = 0;
      depth++;
    end
    return 1'b0;
  endfunction

  // fold one accepted command word into the predictor, queueing expected words
  task automatic predict_command(input bmm_pkg::in_word_t w);
    logic [31:0] greedy_hit;
    int unsigned total;
    int unsigned first_idx;
    bmm_pkg::out_word_t o;
    case (bmm_pkg::func_e'(w.func))
      bmm_pkg::FUNC_ADD: adj_rows[w.left_vertex][w.right_vertex] = 1'b1;
      bmm_pkg::FUNC_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
        partner_set = '0;
      end
      bmm_pkg::FUNC_COMPUTE: begin
        partner_set = '0;
        greedy_hit = '0;
        total = 0;
        for (int l = 0; l < n_left; l++)
          for (int r = 0; r < n_right; r++)
            if (adj_rows[l][r] && !partner_set[r]) begin
              partner_of[r] = l[4:0];
              partner_set[r] = 1'b1;
              greedy_hit[l] = 1'b1;
              total++;
              break;
            end
        for (int l = 0; l < n_left; l++)
          if (!greedy_hit[l] && try_augment(l)) total++;
        first_idx = pending_words.size();
        for (int r = 0; r < n_right; r++)
          if (partner_set[r]) begin
            o = '{pair_valid: 1'b1, pair_left: partner_of[r], pair_right: r[4:0],
                  match_total: total[5:0], last: 1'b0};
            pending_words.insert(pending_words.size(), o);
          end
        if (pending_words.size() == first_idx) begin
          o = '{pair_valid: 1'b0, pair_left: 5'd0, pair_right: 5'd0,
                match_total: 6'd0, last: 1'b1};
          pending_words.insert(pending_words.size(), o);
        end else begin
          pending_words[$].last = 1'b1;
        end
      end
      default: ;  // unused code leaves everything alone
    endcase
  endtask

  // result monitor: one word per done strobe, compared with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %p", out_word_o));
      end else begin
        automatic bmm_pkg::out_word_t exp_w = pending_words.pop_front();
        if (out_word_o.pair_valid !== exp_w.pair_valid)
          report_mismatch($sformatf("pair_valid %b exp %b", out_word_o.pair_valid,
                                    exp_w.pair_valid));
        if (out_word_o.pair_left !== exp_w.pair_left)
          report_mismatch($sformatf("pair_left %0d exp %0d", out_word_o.pair_left,
                                    exp_w.pair_left));
        if (out_word_o.pair_right !== exp_w.pair_right)
          report_mismatch($sformatf("pair_right %0d exp %0d", out_word_o.pair_right,
                                    exp_w.pair_right));
        if (out_word_o.match_total !== exp_w.match_total)
          report_mismatch($sformatf("match_total %0d exp %0d", out_word_o.match_total,
                                    exp_w.match_total));
        if (out_word_o.last !== exp_w.last)
          report_mismatch($sformatf("last %b exp %b", out_word_o.last, exp_w.last));
      end
    end
  end

  // hand one command word over, with random idle cycles in front of it;
  // start stays up after the accept so a following word can go back to back
  task automatic send_word(input bmm_pkg::in_word_t w);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy);
    predict_command(w);
  endtask

  // wait for every expected word, then let a clear or stray add finish
  task automatic drain;
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only while idle
  task automatic write_count(input logic idx, input logic [bmm_pkg::CountW-1:0] val);
    int unsigned eff;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    eff = (val > 32) ? 32 : val;
    if (idx == bmm_pkg::CFG_LEFT) n_left = eff;
    else n_right = eff;
    @(posedge clk_i);
  endtask

  function automatic bmm_pkg::in_word_t mk(input bmm_pkg::func_e f, input int unsigned l,
                                           input int unsigned r);
    mk = '{func: f, left_vertex: l[4:0], right_vertex: r[4:0]};
  endfunction

  // directed rows; typed expectations only for the empty computes after reset and after the clear
  typedef struct {
    bmm_pkg::in_word_t  w;
    bit                 typed;
    bmm_pkg::out_word_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  task automatic queue_row(input bmm_pkg::in_word_t w, input bit typed,
                           input bmm_pkg::out_word_t want);
    stim_row_t row;
    row.w = w;
    row.typed = typed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // random edges, mostly inside the active counts, now and then an unused code word, then a compute
  task automatic random_graph(input int unsigned edges);
    int unsigned l;
    int unsigned r;
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(9) == 0) begin
        l = $urandom_range(31);
        r = $urandom_range(31);
      end else begin
        l = $urandom_range(n_left - 1);
        r = $urandom_range(n_right - 1);
      end
      send_word(mk(bmm_pkg::FUNC_ADD, l, r));
    end
    if ($urandom_range(15) == 0) send_word(mk(bmm_pkg::FUNC_NONE, $urandom, $urandom));
    send_word(mk(bmm_pkg::FUNC_COMPUTE, $urandom, $urandom));
  endtask

  initial begin
    foreach (adj_rows[i]) adj_rows[i] = '0;
    partner_set = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty compute, extremes, crossing edges that force an augmenting path
    queue_row(mk(bmm_pkg::FUNC_COMPUTE, 0, 0), 1'b1, '{1'b0, 5'd0, 5'd0, 6'd0, 1'b1});
    queue_row(mk(bmm_pkg::FUNC_NONE, 31, 31), 1'b0, '0);
    queue_row(mk(bmm_pkg::FUNC_ADD, 0, 0), 1'b0, '0);
    queue_row(mk(bmm_pkg::FUNC_ADD, 0, 0), 1'b0, '0);
    queue_row(mk(bmm_pkg::FUNC_ADD, 0, 1), 1'b0, '0);
    queue_row(mk(bmm_pkg::FUNC_ADD, 1, 0), 1'b0, '0);
    queue_row(mk(bmm_pkg::FUNC_ADD, 31, 31), 1'b0, '0);
    queue_row(mk(bmm_pkg::FUNC_ADD, 31, 0), 1'b0, '0);
    queue_row(mk(bmm_pkg::FUNC_ADD, 2, 0), 1'b0, '0);
    queue_row(mk(bmm_pkg::FUNC_COMPUTE, 0, 0), 1'b0, '0);
    queue_row(mk(bmm_pkg::FUNC_CLEAR, 31, 31), 1'b0, '0);
    queue_row(mk(bmm_pkg::FUNC_COMPUTE, 31, 31), 1'b1, '{1'b0, 5'd0, 5'd0, 6'd0, 1'b1});
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].w);
      if (directed_rows[i].typed && pending_words.size() != 0)
        pending_words[$] = directed_rows[i].want;
    end
    drain();

    // small counts: out-of-range edges stay stored but unused
    write_count(bmm_pkg::CFG_LEFT, 6'd1);
    write_count(bmm_pkg::CFG_RIGHT, 6'd1);
    send_word(mk(bmm_pkg::FUNC_ADD, 5, 5));
    send_word(mk(bmm_pkg::FUNC_COMPUTE, 0, 0));
    drain();
    write_count(bmm_pkg::CFG_LEFT, 6'd63);   // saturates
    write_count(bmm_pkg::CFG_RIGHT, 6'd40);
    send_word(mk(bmm_pkg::FUNC_COMPUTE, 0, 0));
    drain();
    write_count(bmm_pkg::CFG_LEFT, 6'd0);    // no left vertices at all
    send_word(mk(bmm_pkg::FUNC_COMPUTE, 0, 0));
    drain();
    write_count(bmm_pkg::CFG_LEFT, 6'd32);
    write_count(bmm_pkg::CFG_RIGHT, 6'd32);

    // random phases: sender idles 23%, then 88%, then never; drains midway and before each count write
    for (int phase = 0; phase < 3; phase++) begin
      sender_gap_pct = (phase == 0) ? 23 : (phase == 1) ? 88 : 0;
      for (int g = 0; g < 12; g++) begin
        if ($urandom_range(2) == 0) send_word(mk(bmm_pkg::FUNC_CLEAR, $urandom, $urandom));
        random_graph($urandom_range(1, 10));
        if (g == 5) drain();
        if (g % 4 == 3) begin
          drain();
          write_count($urandom_range(1), $urandom_range(1, 32));
        end
      end
      drain();
      // a full-size graph at the end of every phase: the anti-diagonal plus edge 0,0
      write_count(bmm_pkg::CFG_LEFT, 6'd32);
      write_count(bmm_pkg::CFG_RIGHT, 6'd32);
      send_word(mk(bmm_pkg::FUNC_CLEAR, 0, 0));
      for (int l = 0; l < 32; l++) send_word(mk(bmm_pkg::FUNC_ADD, l, 31 - l));
      send_word(mk(bmm_pkg::FUNC_ADD, 0, 0));
      send_word(mk(bmm_pkg::FUNC_COMPUTE, 0, 0));
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (error_count == 0)
      $display("bipartite_max_matching regression: pass");
    else
      $display("bipartite_max_matching regression: fail");
    $finish;
  end

  initial begin
    #500ms;
    $display("bipartite_max_matching regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
src/bmm_pkg.sv
src/bmm_seq.sv
src/bipartite_max_matching.sv
tb/sv/bipartite_max_matching_tb.sv
